@@ rtl/alist_pkg.sv @@
// Package for the array list unit: sizes, codes, state encoding and the
// packed request and result types. No dependencies.
`default_nettype none

package alist_pkg;

  // Storage size and field widths.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned VAL_W    = 32;

  // Request codes.
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  // Control sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_SEARCH,
    S_RESULT
  } state_e;

  // One request.
  typedef struct packed {
    action_e                  action;
    logic [IDX_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;
  } in_item_t;

  // One result.
  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  found_index;
    logic [CNT_W-1:0]  count;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/alist_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module alist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/array_list_insert_remove_search_unit.sv @@
// Top level of the array list unit: request decode, remove and search
// sequencer, result register. Depends on alist_pkg and alist_ram.
//
// Usage. Requests arrive on the in channel (in_valid_i / in_ready_o /
// in_item_i) and each one gives exactly one result on the out channel
// (out_valid_o / out_ready_i / out_item_o). A transfer happens at a rising
// edge with valid and ready both high.
// Insert, the no-op code and every rejected request go from the accepting
// edge straight to the result state. A remove streams the later entries
// down one place through the entry RAM, one read and one write per cycle,
// before its result is staged. A search reads the entry RAM from the head,
// one read per cycle, and stops on the first match or at the count. One
// request is in work at a time, and the next one can be taken the cycle
// after the result is loaded.
// Reset clears the count and the control state; stored entries are not
// cleared, since only entries below the count are ever read.
// A result waits in the output register while the receiver stalls; the next
// request is accepted meanwhile, and its result is held back until the
// register is free.
`default_nettype none

module array_list_insert_remove_search_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire alist_pkg::in_item_t  in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output alist_pkg::out_item_t      out_item_o
);

  import alist_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rd_q, rd_d;
  logic [IDX_W-1:0]  la_q, la_d;
  logic              pend_q, pend_d;
  logic [VAL_W-1:0]  key_q, key_d;
  status_e           res_status_q, res_status_d;
  logic [IDX_W-1:0]  res_found_q, res_found_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;
  logic              in_xfer;

  // Entry storage.
  alist_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rd_q         <= rd_d;
    la_q         <= la_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    out_item_q   <= out_item_d;
  end

  // Next state, RAM accesses and result staging.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_d         = rd_q;
    la_d         = la_q;
    pend_d       = 1'b0;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q;
    out_item_d   = out_item_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[IDX_W-1:0];
    ram_wdata    = in_item_i.value;
    ram_re       = 1'b0;
    ram_raddr    = rd_q[IDX_W-1:0];

    // The receiver drains the output register.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_status_d = ST_OK;
          res_found_d  = '0;
          state_d      = S_RESULT;
          case (in_item_i.action)
            ACT_INSERT: begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                res_status_d = ST_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            ACT_REMOVE: begin
              if ({1'b0, in_item_i.position} >= count_q) begin
                res_status_d = ST_RANGE;
              end else begin
                count_d = count_q - 1'b1;
                rd_d    = {1'b0, in_item_i.position} + 1'b1;
                state_d = S_REMOVE;
              end
            end
            ACT_SEARCH: begin
              key_d   = in_item_i.value;
              rd_d    = '0;
              state_d = S_SEARCH;
            end
            default: begin
            end
          endcase
        end
      end

      // Stream later entries down one place: read at rd, write the
      // previous read one position lower.
      S_REMOVE: begin
        if (rd_q <= count_q) begin
          ram_re = 1'b1;
          la_d   = rd_q[IDX_W-1:0];
          rd_d   = rd_q + 1'b1;
          pend_d = 1'b1;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = la_q - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (!pend_q && (rd_q > count_q)) begin
          state_d = S_RESULT;
        end
      end

      // Scan from the head, one compare per cycle, stop on the first match.
      S_SEARCH: begin
        if (pend_q && (ram_rdata == key_q)) begin
          res_status_d = ST_OK;
          res_found_d  = la_q;
          state_d      = S_RESULT;
        end else if (rd_q < count_q) begin
          ram_re = 1'b1;
          la_d   = rd_q[IDX_W-1:0];
          rd_d   = rd_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          res_status_d = ST_MISS;
          res_found_d  = '0;
          state_d      = S_RESULT;
        end
      end

      // Load the output register once it is free.
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_item_d.status      = res_status_q;
          out_item_d.found_index = res_found_q;
          out_item_d.count       = count_q;
          state_d                = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The count moves only when a request is accepted.
  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(in_xfer))
    else $error("entry count changed without a request transfer");

  // RAM writes occur only for an accepted insert or during compaction.
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (in_xfer || (state_q == S_REMOVE)))
    else $error("RAM write outside insert or remove");

  // Compaction never writes at or above the new count.
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q == S_REMOVE)) |-> ({1'b0, ram_waddr} < count_q))
    else $error("compaction write beyond the list tail");

endmodule

`default_nettype wire

@@ dv/list_result_check.sv @@
`timescale 1ns / 100ps
// Result checker for the array list unit: watches both channels, keeps its own
// copy of the list, and compares every result against the predicted one.
// Depends on alist_pkg.

module list_result_check (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  alist_pkg::in_item_t  in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  alist_pkg::out_item_t out_item_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  import alist_pkg::*;

  // Shadow copy of the list contents and length.
  logic [VAL_W-1:0] shadow_entries [CAPACITY];
  int unsigned      shadow_len;

  // Results predicted for accepted requests, oldest first.
  out_item_t        expected_results [$];
  out_item_t        oldest;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    shadow_len   = 0;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  // Apply one request to the shadow list and return the result it gives.
  function automatic out_item_t apply_request(in_item_t req);
    out_item_t res;
    res.status      = ST_OK;
    res.found_index = '0;
    case (req.action)
      ACT_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[shadow_len] = req.value;
          shadow_len++;
        end
      end
      ACT_REMOVE: begin
        // An empty list fails this test as well, since no position is below zero.
        if (req.position >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = req.position; i < shadow_len - 1; i++) begin
            shadow_entries[i] = shadow_entries[i + 1];
          end
          shadow_len--;
        end
      end
      ACT_SEARCH: begin
        // The lowest matching position wins.
        res.status = ST_MISS;
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_entries[i] == req.value) begin
            res.status      = ST_OK;
            res.found_index = IDX_W'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(shadow_len);
    return res;
  endfunction

  // Compare each result transfer first, then predict for a request transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_len = 0;
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting (status %0d count %0d)",
                                    out_item_i.status, out_item_i.count));
        end else begin
          oldest = expected_results.pop_front();
          if (out_item_i.status !== oldest.status) begin
            report_mismatch($sformatf("status got %0d, expected %0d",
                                      out_item_i.status, oldest.status));
          end
          if (out_item_i.found_index !== oldest.found_index) begin
            report_mismatch($sformatf("found_index got %0d, expected %0d",
                                      out_item_i.found_index, oldest.found_index));
          end
          if (out_item_i.count !== oldest.count) begin
            report_mismatch($sformatf("count got %0d, expected %0d",
                                      out_item_i.count, oldest.count));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(apply_request(in_item_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the array list unit: clock, reset, request and result
// traffic, watchdog and verdict. Depends on alist_pkg, the unit and
// list_result_check.

module tb;
  import alist_pkg::*;

  localparam int NUM_RANDOM     = 530;
  localparam int CALM_TAIL      = 80;
  localparam int MODE_SPAN      = 48;
  localparam int WATCHDOG_LIMIT = 600;
  localparam int SETTLE_CYCLES  = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int        fail_count;
  int        pending;
  int        quiet_cycles = 0;
  bit        idle_on = 1'b1;
  bit        filling = 1'b1;
  logic [VAL_W-1:0] key_pool [8];

  always #5 clk = ~clk;

  array_list_insert_remove_search_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  list_result_check u_result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Present one request until it is transferred, then maybe pause the sender.
  task automatic send_request(action_e act, logic [IDX_W-1:0] pos, logic [VAL_W-1:0] val);
    in_item_t req;
    req.action   = act;
    req.position = pos;
    req.value    = val;
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Values come half from a small pool, so searches hit and duplicates occur.
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) begin
      return key_pool[$urandom_range(0, 7)];
    end
    return $urandom;
  endfunction

  // One random request; the fill mode leans toward inserts, the drain mode
  // toward removes, so the list swings between full and empty.
  task automatic send_random_request();
    int unsigned      roll;
    logic [IDX_W-1:0] pos;
    action_e          act;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      pos = IDX_W'($urandom_range(0, 3));
    end else begin
      pos = IDX_W'($urandom);
    end
    if (roll < 4) begin
      act = ACT_NOP;
    end else if (filling) begin
      act = (roll < 60) ? ACT_INSERT : (roll < 75) ? ACT_REMOVE : ACT_SEARCH;
    end else begin
      act = (roll < 30) ? ACT_INSERT : (roll < 65) ? ACT_REMOVE : ACT_SEARCH;
    end
    send_request(act, pos, pick_value());
  endtask

  // Result side: ready with random stall bursts while idling is on.
  initial begin
    @(posedge rst_n);
    @(negedge clk);
    out_ready <= 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** array_list_insert_remove_search_unit: FAILED **");
      $finish;
    end
  end

  // Request side: reset, directed requests, random requests, verdict.
  initial begin
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty list: search misses, remove is out of range, no-op leaves it alone.
    send_request(ACT_SEARCH, 4'h0, 32'h0000_0000);
    send_request(ACT_REMOVE, 4'h0, 32'h0000_0000);
    send_request(ACT_NOP,    4'hF, 32'hFFFF_FFFF);
    // Extreme values, with a duplicate of the most negative one.
    send_request(ACT_INSERT, 4'hF, 32'h8000_0000);
    send_request(ACT_INSERT, 4'h0, 32'h7FFF_FFFF);
    send_request(ACT_INSERT, 4'hA, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 4'h5, 32'h8000_0000);
    send_request(ACT_INSERT, 4'h0, 32'h0000_0000);
    // Searches: lowest duplicate, last entry, a miss, all ones.
    send_request(ACT_SEARCH, 4'hF, 32'h8000_0000);
    send_request(ACT_SEARCH, 4'h0, 32'h0000_0000);
    send_request(ACT_SEARCH, 4'h0, 32'h0000_0001);
    send_request(ACT_SEARCH, 4'h0, 32'hFFFF_FFFF);
    // Removes: at the count, far beyond it, head, tail, middle.
    send_request(ACT_REMOVE, 4'h5, 32'h0000_0000);
    send_request(ACT_REMOVE, 4'hF, 32'h0000_0000);
    send_request(ACT_REMOVE, 4'h0, 32'h1234_5678);
    send_request(ACT_SEARCH, 4'h0, 32'h8000_0000);
    send_request(ACT_REMOVE, 4'h3, 32'h0000_0000);
    send_request(ACT_REMOVE, 4'h1, 32'h0000_0000);
    send_request(ACT_NOP,    4'hA, 32'h5555_5555);

    wait_results_drained();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - CALM_TAIL) idle_on = 1'b0;
      if (n % MODE_SPAN == 0) filling = !filling;
      if (n == NUM_RANDOM / 2) wait_results_drained();
      send_random_request();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("** array_list_insert_remove_search_unit: PASSED **");
    end else begin
      $display("** array_list_insert_remove_search_unit: FAILED **");
    end
    $finish;
  end

endmodule
